@@ rtl/core/ifr_pkg.sv @@
// ifr_pkg: shared types and constants for the info frame receiver.
// No dependencies.
package ifr_pkg;

	localparam logic [7:0] FLAG_OCTET = 8'h7E;
	localparam logic [7:0] ESC_OCTET  = 8'h7D;
	localparam logic [7:0] ESC_FLAG   = 8'h5E;
	localparam logic [7:0] ESC_ESC    = 8'h5D;
	localparam logic [7:0] CTRL_I0    = 8'h00;
	localparam logic [7:0] CTRL_I1    = 8'h40;
	localparam logic [7:0] REPLY_RR1  = 8'h85;
	localparam logic [7:0] REPLY_RR0  = 8'h05;
	localparam logic [7:0] REPLY_REJ1 = 8'h81;
	localparam logic [7:0] REPLY_REJ0 = 8'h01;
	localparam logic [7:0] ADDR_RESET = 8'h03;

	localparam logic [1:0] VERDICT_NEW     = 2'd0;
	localparam logic [1:0] VERDICT_DUP     = 2'd1;
	localparam logic [1:0] VERDICT_BAD_FCS = 2'd2;
	localparam logic [1:0] VERDICT_BAD_ESC = 2'd3;

	// operations passed from front to back
	localparam logic [1:0] OP_PAY    = 2'd0;
	localparam logic [1:0] OP_CLOSE  = 2'd1;
	localparam logic [1:0] OP_BADESC = 2'd2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic       seq;
	} ifr_op_t;

endpackage

@@ rtl/core/info_frame_receiver.sv @@
// info_frame_receiver: top level of the I-frame deframer.
// Depends on ifr_pkg, ifr_front, ifr_queue, ifr_back.
//
//  channel | handshake               | payload
//  in      | in_valid / in_ready     | rx_byte
//  out     | out_valid / out_ready   | out_kind, data_byte, verdict, reply_valid,
//          |                         | reply_control, frame_sequence
//  cfg     | cfg_wr_en               | cfg_wr_data (address byte)
//
// One word per cycle in while the op queue has room; each op is registered in the
// queue, then in the back output register; a payload byte is held until the next one.
// Front and back meet in a 4-entry op queue; in_ready drops only when it is full.
// The output register is reloaded in the cycle it is taken.
// arst_n clears all control state; the address register resets to 0x03.
module info_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_kind,
	output logic [7:0] data_byte,
	output logic [1:0] verdict,
	output logic       reply_valid,
	output logic [7:0] reply_control,
	output logic       frame_sequence
);

	logic             push, q_full, pop, q_valid;
	ifr_pkg::ifr_op_t push_op, q_op;

	ifr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.q_full      (q_full),
		.push        (push),
		.push_op     (push_op)
	);

	ifr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_op    (q_op)
	);

	ifr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_op           (q_op),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_kind       (out_kind),
		.data_byte      (data_byte),
		.verdict        (verdict),
		.reply_valid    (reply_valid),
		.reply_control  (reply_control),
		.frame_sequence (frame_sequence)
	);

endmodule

@@ rtl/core/ifr_front.sv @@
// ifr_front: flag hunt, header check and destuffing; emits ops to the queue.
// Depends on ifr_pkg.
module ifr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_byte,
	input  logic             q_full,
	output logic             push,
	output ifr_pkg::ifr_op_t push_op
);

	localparam logic [2:0] ST_HUNT = 3'd0;
	localparam logic [2:0] ST_FLAG = 3'd1;
	localparam logic [2:0] ST_ADDR = 3'd2;
	localparam logic [2:0] ST_CTRL = 3'd3;
	localparam logic [2:0] ST_DATA = 3'd4;
	localparam logic [2:0] ST_ESC  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       seq_q, seq_d;
	logic [7:0] addr_q;
	logic       accept;
	logic [7:0] hcs;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign hcs      = addr_q ^ (seq_q ? ifr_pkg::CTRL_I1 : ifr_pkg::CTRL_I0);

	always_comb begin
		state_d      = state_q;
		seq_d        = seq_q;
		push         = 1'b0;
		push_op.op   = ifr_pkg::OP_PAY;
		push_op.data = rx_byte;
		push_op.seq  = seq_q;
		unique case (state_q)
			ST_FLAG: begin
				if (rx_byte == addr_q)
					state_d = ST_ADDR;
				else if (rx_byte != ifr_pkg::FLAG_OCTET)
					state_d = ST_HUNT;
			end
			ST_ADDR: begin
				if (rx_byte == ifr_pkg::CTRL_I0 || rx_byte == ifr_pkg::CTRL_I1) begin
					seq_d   = (rx_byte == ifr_pkg::CTRL_I1);
					state_d = ST_CTRL;
				end else if (rx_byte == ifr_pkg::FLAG_OCTET) begin
					state_d = ST_FLAG;
				end else begin
					state_d = ST_HUNT;
				end
			end
			ST_CTRL: begin
				if (rx_byte == hcs)
					state_d = ST_DATA;
				else if (rx_byte == ifr_pkg::FLAG_OCTET)
					state_d = ST_FLAG;
				else
					state_d = ST_HUNT;
			end
			ST_DATA: begin
				if (rx_byte == ifr_pkg::FLAG_OCTET) begin
					state_d    = ST_HUNT;
					push       = 1'b1;
					push_op.op = ifr_pkg::OP_CLOSE;
				end else if (rx_byte == ifr_pkg::ESC_OCTET) begin
					state_d = ST_ESC;
				end else begin
					push = 1'b1;
				end
			end
			ST_ESC: begin
				push = 1'b1;
				if (rx_byte == ifr_pkg::ESC_FLAG) begin
					state_d      = ST_DATA;
					push_op.data = ifr_pkg::FLAG_OCTET;
				end else if (rx_byte == ifr_pkg::ESC_ESC) begin
					state_d      = ST_DATA;
					push_op.data = ifr_pkg::ESC_OCTET;
				end else begin
					state_d    = ST_HUNT;
					push_op.op = ifr_pkg::OP_BADESC;
				end
			end
			default: begin
				state_d = (rx_byte == ifr_pkg::FLAG_OCTET) ? ST_FLAG : ST_HUNT;
			end
		endcase
		if (!accept)
			push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			seq_q   <= 1'b0;
			addr_q  <= ifr_pkg::ADDR_RESET;
		end else begin
			if (accept) begin
				state_q <= state_d;
				seq_q   <= seq_d;
			end
			if (cfg_wr_en)
				addr_q <= cfg_wr_data;
		end
	end

endmodule

@@ rtl/core/ifr_queue.sv @@
// ifr_queue: small FIFO of ops between front and back.
// Depends on ifr_pkg.
module ifr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ifr_pkg::ifr_op_t push_op,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output ifr_pkg::ifr_op_t q_op
);

	ifr_pkg::ifr_op_t               ent_q [ifr_pkg::QDEPTH];
	logic [ifr_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [ifr_pkg::QCNT_W-1:0]     count_q;

	assign full    = (count_q == ifr_pkg::QCNT_W'(ifr_pkg::QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_op    = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty op queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full) else $error("push into full op queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("op queue count did not advance");
`endif

endmodule

@@ rtl/core/ifr_back.sv @@
// ifr_back: one-byte holdback, payload check, sequence tracking, output register.
// Depends on ifr_pkg.
module ifr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  ifr_pkg::ifr_op_t q_op,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_kind,
	output logic [7:0]       data_byte,
	output logic [1:0]       verdict,
	output logic             reply_valid,
	output logic [7:0]       reply_control,
	output logic             frame_sequence
);

	logic       out_valid_q;
	logic       kind_q, rvalid_q, fseq_q;
	logic [7:0] data_q, rctl_q;
	logic [1:0] verdict_q;
	logic [7:0] pend_b_q, parity_q;
	logic       pend_v_q, seen_q, exp_seq_q;
	logic       advance, good;

	assign advance = !out_valid_q || out_ready;
	assign pop     = q_valid && advance;
	assign good    = pend_v_q && seen_q && (parity_q == pend_b_q);

	assign out_valid      = out_valid_q;
	assign out_kind       = kind_q;
	assign data_byte      = data_q;
	assign verdict        = verdict_q;
	assign reply_valid    = rvalid_q;
	assign reply_control  = rctl_q;
	assign frame_sequence = fseq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
			seen_q      <= 1'b0;
			parity_q    <= '0;
			exp_seq_q   <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b0;
			if (pop) begin
				unique case (q_op.op)
					ifr_pkg::OP_PAY: begin
						if (pend_v_q) begin
							out_valid_q <= 1'b1;
							parity_q    <= parity_q ^ pend_b_q;
							seen_q      <= 1'b1;
						end
						pend_v_q <= 1'b1;
					end
					ifr_pkg::OP_CLOSE: begin
						out_valid_q <= 1'b1;
						pend_v_q    <= 1'b0;
						seen_q      <= 1'b0;
						parity_q    <= '0;
						if (good && q_op.seq == exp_seq_q)
							exp_seq_q <= !exp_seq_q;
					end
					default: begin
						out_valid_q <= 1'b1;
						pend_v_q    <= 1'b0;
						seen_q      <= 1'b0;
						parity_q    <= '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (q_op.op)
				ifr_pkg::OP_PAY: begin
					kind_q    <= 1'b0;
					data_q    <= pend_b_q;
					verdict_q <= ifr_pkg::VERDICT_NEW;
					rvalid_q  <= 1'b0;
					rctl_q    <= '0;
					fseq_q    <= 1'b0;
					pend_b_q  <= q_op.data;
				end
				ifr_pkg::OP_CLOSE: begin
					kind_q   <= 1'b1;
					data_q   <= '0;
					rvalid_q <= 1'b1;
					fseq_q   <= q_op.seq;
					if (good) begin
						verdict_q <= (q_op.seq == exp_seq_q) ? ifr_pkg::VERDICT_NEW
						                                     : ifr_pkg::VERDICT_DUP;
						rctl_q    <= q_op.seq ? ifr_pkg::REPLY_RR0 : ifr_pkg::REPLY_RR1;
					end else begin
						verdict_q <= ifr_pkg::VERDICT_BAD_FCS;
						rctl_q    <= q_op.seq ? ifr_pkg::REPLY_REJ0 : ifr_pkg::REPLY_REJ1;
					end
				end
				default: begin
					kind_q    <= 1'b1;
					data_q    <= '0;
					verdict_q <= ifr_pkg::VERDICT_BAD_ESC;
					rvalid_q  <= 1'b0;
					rctl_q    <= '0;
					fseq_q    <= q_op.seq;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_close_drops_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_op.op == ifr_pkg::OP_CLOSE) |=> !pend_v_q && out_valid_q)
		else $error("frame close left a held byte or no report");
	a_pay_holds_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_op.op == ifr_pkg::OP_PAY) |=> pend_v_q)
		else $error("payload byte not held back");
`endif

endmodule

@@ sim/tb_info_frame_receiver.sv @@
`timescale 1ns / 1ps
// tb_info_frame_receiver: self-checking bench for the I-frame deframer. It drives directed
// and random link bytes and checks every output word against a local deframer model.
// Depends on ifr_pkg and info_frame_receiver.
module tb_info_frame_receiver;
	import ifr_pkg::*;

	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS    = 185;
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	typedef enum logic [2:0] {RX_HUNT, RX_FLAG, RX_ADDR, RX_CTRL, RX_DATA, RX_ESC} rx_state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [1:0] verdict;
		logic       reply_valid;
		logic [7:0] reply_control;
		logic       seq;
	} deframed_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       out_kind;
	logic [7:0] data_byte;
	logic [1:0] verdict;
	logic       reply_valid;
	logic [7:0] reply_control;
	logic       frame_sequence;

	rx_state_t  rx_state = RX_HUNT;
	logic [7:0] addr_reg = ADDR_RESET;
	logic       cur_seq = 1'b0;
	logic       next_seq = 1'b0;
	logic [7:0] parity = 8'h00;
	logic [7:0] held_byte = 8'h00;
	logic       held_valid = 1'b0;
	logic       released_any = 1'b0;

	deframed_t  deframed_due[$];
	logic [7:0] frame_bytes[$];
	int         errors = 0;
	bit         idle_on = 1'b1;
	int         stall_left = 0;
	int         idle_cycles = 0;

	info_frame_receiver uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind(out_kind),
		.data_byte(data_byte),
		.verdict(verdict),
		.reply_valid(reply_valid),
		.reply_control(reply_control),
		.frame_sequence(frame_sequence)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pause_cycles();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] pick_octet();
		case ($urandom_range(0, 15))
			0: return FLAG_OCTET;
			1: return ESC_OCTET;
			2: return ESC_FLAG;
			3: return ESC_ESC;
			4: return 8'h00;
			5: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// destuffed byte goes into the hold slot; the previous one is released
	task automatic release_octet(input logic [7:0] b);
		if (held_valid) begin
			deframed_due.push_back({KIND_PAYLOAD, held_byte, VERDICT_NEW, 1'b0, 8'h00, 1'b0});
			parity = parity ^ held_byte;
			released_any = 1'b1;
		end
		held_byte = b;
		held_valid = 1'b1;
	endtask

	task automatic deframe_word(input logic [7:0] b);
		logic good;
		case (rx_state)
			RX_FLAG: begin
				if (b == addr_reg)
					rx_state = RX_ADDR;
				else if (b != FLAG_OCTET)
					rx_state = RX_HUNT;
			end
			RX_ADDR: begin
				if (b == CTRL_I0 || b == CTRL_I1) begin
					cur_seq = (b == CTRL_I1);
					rx_state = RX_CTRL;
				end else if (b == FLAG_OCTET) begin
					rx_state = RX_FLAG;
				end else begin
					rx_state = RX_HUNT;
				end
			end
			RX_CTRL: begin
				if (b == (addr_reg ^ (cur_seq ? CTRL_I1 : CTRL_I0))) begin
					rx_state = RX_DATA;
					parity = 8'h00;
					held_valid = 1'b0;
					released_any = 1'b0;
				end else if (b == FLAG_OCTET) begin
					rx_state = RX_FLAG;
				end else begin
					rx_state = RX_HUNT;
				end
			end
			RX_DATA: begin
				if (b == FLAG_OCTET) begin
					good = held_valid && released_any && (parity == held_byte);
					rx_state = RX_HUNT;
					held_valid = 1'b0;
					if (!good) begin
						deframed_due.push_back({KIND_REPORT, 8'h00, VERDICT_BAD_FCS, 1'b1,
							cur_seq ? REPLY_REJ0 : REPLY_REJ1, cur_seq});
					end else if (cur_seq == next_seq) begin
						deframed_due.push_back({KIND_REPORT, 8'h00, VERDICT_NEW, 1'b1,
							cur_seq ? REPLY_RR0 : REPLY_RR1, cur_seq});
						next_seq = ~next_seq;
					end else begin
						deframed_due.push_back({KIND_REPORT, 8'h00, VERDICT_DUP, 1'b1,
							cur_seq ? REPLY_RR0 : REPLY_RR1, cur_seq});
					end
				end else if (b == ESC_OCTET) begin
					rx_state = RX_ESC;
				end else begin
					release_octet(b);
				end
			end
			RX_ESC: begin
				if (b == ESC_FLAG) begin
					rx_state = RX_DATA;
					release_octet(FLAG_OCTET);
				end else if (b == ESC_ESC) begin
					rx_state = RX_DATA;
					release_octet(ESC_OCTET);
				end else begin
					rx_state = RX_HUNT;
					held_valid = 1'b0;
					deframed_due.push_back({KIND_REPORT, 8'h00, VERDICT_BAD_ESC, 1'b0, 8'h00,
						cur_seq});
				end
			end
			default: begin
				rx_state = (b == FLAG_OCTET) ? RX_FLAG : RX_HUNT;
			end
		endcase
	endtask

	task automatic send_word(input logic [7:0] b);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? pause_cycles() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		deframe_word(b);
	endtask

	task automatic send_frame_bytes();
		foreach (frame_bytes[i])
			send_word(frame_bytes[i]);
		frame_bytes.delete();
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (deframed_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_address(input logic [7:0] addr);
		wait_drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= addr;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		addr_reg = addr;
	endtask

	task automatic send_random_frame(inout int words);
		logic [7:0] payload[$];
		logic [7:0] v;
		logic [7:0] chk;
		logic       seq;
		int         len;
		seq = 1'($urandom_range(0, 1));
		repeat ($urandom_range(1, 2)) frame_bytes.push_back(FLAG_OCTET);
		frame_bytes.push_back(($urandom_range(0, 19) == 0) ? pick_octet() : addr_reg);
		frame_bytes.push_back(($urandom_range(0, 19) == 0) ? pick_octet() :
			(seq ? CTRL_I1 : CTRL_I0));
		frame_bytes.push_back(($urandom_range(0, 19) == 0) ? pick_octet() :
			(addr_reg ^ (seq ? CTRL_I1 : CTRL_I0)));
		len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
		chk = 8'h00;
		repeat (len) begin
			v = pick_octet();
			payload.push_back(v);
			chk = chk ^ v;
		end
		if ($urandom_range(0, 7) == 0)
			chk = chk ^ 8'($urandom_range(1, 255));
		payload.push_back(chk);
		foreach (payload[i]) begin
			if ($urandom_range(0, 29) == 0) begin
				do v = pick_octet(); while (v == ESC_FLAG || v == ESC_ESC);
				frame_bytes.push_back(ESC_OCTET);
				frame_bytes.push_back(v);
			end else if (payload[i] == FLAG_OCTET) begin
				frame_bytes.push_back(ESC_OCTET);
				frame_bytes.push_back(ESC_FLAG);
			end else if (payload[i] == ESC_OCTET) begin
				frame_bytes.push_back(ESC_OCTET);
				frame_bytes.push_back(ESC_ESC);
			end else begin
				frame_bytes.push_back(payload[i]);
			end
		end
		frame_bytes.push_back(FLAG_OCTET);
		words += frame_bytes.size();
		send_frame_bytes();
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		deframed_t exp_w;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (deframed_due.size() == 0) begin
				$display("%0t: unexpected word, expected none actual kind %b data %h verdict %0d",
					$time, out_kind, data_byte, verdict);
				errors++;
			end else begin
				exp_w = deframed_due.pop_front();
				check_field("out_kind", 8'(exp_w.kind), 8'(out_kind));
				check_field("data_byte", exp_w.data, data_byte);
				check_field("verdict", 8'(exp_w.verdict), 8'(verdict));
				check_field("reply_valid", 8'(exp_w.reply_valid), 8'(reply_valid));
				check_field("reply_control", exp_w.reply_control, reply_control);
				check_field("frame_sequence", 8'(exp_w.seq), 8'(frame_sequence));
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left = pause_cycles();
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic test_escaped_frame();
		frame_bytes = '{FLAG_OCTET, ADDR_RESET, CTRL_I0, ADDR_RESET ^ CTRL_I0,
			ESC_OCTET, ESC_FLAG, ESC_OCTET, ESC_FLAG, FLAG_OCTET};
		send_frame_bytes();
	endtask

	task automatic test_duplicate_frame();
		frame_bytes = '{FLAG_OCTET, ADDR_RESET, CTRL_I0, ADDR_RESET ^ CTRL_I0,
			ESC_OCTET, ESC_ESC, ESC_OCTET, ESC_ESC, FLAG_OCTET};
		send_frame_bytes();
	endtask

	// flags in header slots restart, then an escape hits a flag
	task automatic test_header_restart_bad_escape();
		frame_bytes = '{FLAG_OCTET, FLAG_OCTET, ADDR_RESET, FLAG_OCTET, ADDR_RESET, CTRL_I1,
			ADDR_RESET ^ CTRL_I1, ESC_OCTET, FLAG_OCTET};
		send_frame_bytes();
	endtask

	task automatic test_empty_payload();
		frame_bytes = '{FLAG_OCTET, ADDR_RESET, CTRL_I1, ADDR_RESET ^ CTRL_I1, 8'hFF,
			FLAG_OCTET};
		send_frame_bytes();
	endtask

	task automatic test_random_frames(input logic [7:0] addr);
		int words;
		set_address(addr);
		words = 0;
		while (words < PHASE_WORDS) begin
			idle_on = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
			send_random_frame(words);
			if ($urandom_range(0, 19) == 0)
				wait_drain();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_escaped_frame();
		test_duplicate_frame();
		test_header_restart_bad_escape();
		test_empty_payload();
		test_random_frames(8'h00);
		test_random_frames(8'hFF);
		test_random_frames(FLAG_OCTET);
		test_random_frames(ESC_OCTET);
		test_random_frames(8'($urandom_range(1, 254)));
		test_random_frames(ADDR_RESET);
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
